@@ design/dcl_pkg.sv @@
// Shared types and constants of the density cluster labeler.
// Used by the cell row, the controller top level and the port checker.
package dcl_pkg;

    localparam int DCL_MAX_POINTS = 64;
    localparam int DCL_COORD_BITS = 16;

    localparam int IN_COORD_W = 16;
    localparam int IDX_W      = 6;
    localparam int LBL_W      = 7;
    localparam int CNT_W      = 7;
    localparam int EPS_W      = 33;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 8;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EPS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINPTS = 8'd1;

    localparam logic [LBL_W-1:0] LBL_NOISE = 7'd0;

    // query word handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             expand;
        logic [CNT_W-1:0] cnt;
        logic [LBL_W-1:0] id;
    } tok_t;

    // broadcast command from the controller to the cell row
    typedef struct packed {
        logic             load;
        logic             clr_pts;
        logic             clr_lbl;
        logic             set_lbl;
        logic             shift;
        logic [LBL_W-1:0] lbl;
    } cmd_t;

endpackage

@@ design/dcl_cell.sv @@
// One point cell: holds a point and its label, checks the passing query word.
// Depends on dcl_pkg for the query word and command types.
module dcl_cell #(
    parameter int COORD_BITS = 16,
    parameter int AW         = 6,
    parameter int CELL_IDX   = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dcl_pkg::cmd_t                 cmd,
    input  logic [AW-1:0]                 cmd_idx,
    input  logic signed [COORD_BITS-1:0]  cmd_x,
    input  logic signed [COORD_BITS-1:0]  cmd_y,
    input  logic [dcl_pkg::EPS_W-1:0]     eps,
    input  dcl_pkg::tok_t                 tok_in,
    input  logic signed [COORD_BITS-1:0]  qx_in,
    input  logic signed [COORD_BITS-1:0]  qy_in,
    output dcl_pkg::tok_t                 tok_out,
    output logic signed [COORD_BITS-1:0]  qx_out,
    output logic signed [COORD_BITS-1:0]  qy_out,
    input  logic [dcl_pkg::LBL_W-1:0]     lbl_in,
    output logic [dcl_pkg::LBL_W-1:0]     lbl_out,
    output logic                          unc_out,
    output logic                          push_out
);
    import dcl_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int EW = (SW > EPS_W) ? SW : EPS_W;

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [LBL_W-1:0]             lbl_reg;
    logic                         unc_reg;
    tok_t                         tok_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic [PW-1:0]                sx_reg, sy_reg;

    logic          hit;
    logic [DW-1:0] diff_x, diff_y, ad_x, ad_y;
    logic [SW-1:0] sum;
    logic          nb;

    assign hit    = (cmd_idx == AW'(CELL_IDX));
    assign diff_x = DW'({qx_in[COORD_BITS-1], qx_in} - {x_reg[COORD_BITS-1], x_reg});
    assign diff_y = DW'({qy_in[COORD_BITS-1], qy_in} - {y_reg[COORD_BITS-1], y_reg});
    assign ad_x   = diff_x[DW-1] ? (~diff_x + DW'(1)) : diff_x;
    assign ad_y   = diff_y[DW-1] ? (~diff_y + DW'(1)) : diff_y;
    assign sum    = SW'(sx_reg) + SW'(sy_reg);
    assign nb     = valid_reg && (EW'(sum) <= EW'(eps));

    always_comb begin
        tok_out = tok_reg;
        if (tok_reg.valid && !tok_reg.expand && nb) begin
            tok_out.cnt = tok_reg.cnt + CNT_W'(1);
        end
    end

    assign qx_out   = qx_reg;
    assign qy_out   = qy_reg;
    assign lbl_out  = lbl_reg;
    assign unc_out  = unc_reg;
    assign push_out = tok_reg.valid && tok_reg.expand && nb && unc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            unc_reg       <= 1'b1;
            tok_reg.valid <= 1'b0;
        end else begin
            if (cmd.clr_pts) begin
                valid_reg <= 1'b0;
            end else if (cmd.load && hit) begin
                valid_reg <= 1'b1;
            end
            tok_reg.valid  <= tok_in.valid;
            tok_reg.expand <= tok_in.expand;
            tok_reg.cnt    <= tok_in.cnt;
            tok_reg.id     <= tok_in.id;
            if (cmd.clr_lbl) begin
                unc_reg <= 1'b1;
            end else if (cmd.set_lbl && hit) begin
                unc_reg <= 1'b0;
            end else if (push_out) begin
                unc_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && hit) begin
            x_reg <= cmd_x;
            y_reg <= cmd_y;
        end
        qx_reg         <= qx_in;
        qy_reg         <= qy_in;
        sx_reg         <= PW'(ad_x) * PW'(ad_x);
        sy_reg         <= PW'(ad_y) * PW'(ad_y);
        // noise reached by a cluster becomes a border point
        if (cmd.shift) begin
            lbl_reg <= lbl_in;
        end else if (cmd.set_lbl && hit) begin
            lbl_reg <= cmd.lbl;
        end else if (tok_reg.valid && tok_reg.expand && nb
                     && (unc_reg || lbl_reg == LBL_NOISE)) begin
            lbl_reg <= tok_reg.id;
        end
    end

endmodule

@@ design/dcl_point_mem.sv @@
// Point coordinate memory: one write port, one registered read port.
// Standalone; no package needed.
module dcl_point_mem #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ design/dcl_seed_queue.sv @@
// Seed FIFO of point indices for cluster growth, registered read.
// Standalone; no package needed.
module dcl_seed_queue #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          restart,
    input  logic          push,
    input  logic [AW-1:0] push_idx,
    input  logic          pop,
    output logic [AW-1:0] rd_idx,
    output logic          empty
);
    logic [AW-1:0] mem [DEPTH];
    logic [CW-1:0] head_reg, tail_reg;
    logic [AW-1:0] rd_idx_reg;

    assign empty  = (head_reg == tail_reg);
    assign rd_idx = rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else if (restart) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            if (push) begin
                tail_reg <= tail_reg + CW'(1);
            end
            if (pop) begin
                head_reg <= head_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg[AW-1:0]] <= push_idx;
        end
        if (pop) begin
            rd_idx_reg <= mem[head_reg[AW-1:0]];
        end
    end

endmodule

@@ design/density_cluster_labeler.sv @@
// Top level: run controller, point memory, seed queue and the row of point cells.
// Depends on dcl_pkg, dcl_cell, dcl_point_mem and dcl_seed_queue.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid/s_tready    tuser op; tdata x_coord, y_coord
//   m_*       out        m_tvalid/m_tready    tdata point_index, cluster_id; tlast
//   cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load and clear words leave the controller idle. A run first counts the
// neighbours of every point, then takes a growth step for each core point that
// grows its cluster, since every growth step sends one query word down the
// whole cell row. Labels are then shifted out of the row, one word per cycle
// while m_tready is high. Reset needs no clearing pass. s_tready is low for
// the whole run.
module density_cluster_labeler #(
    parameter int MAX_POINTS = dcl_pkg::DCL_MAX_POINTS,
    parameter int COORD_BITS = dcl_pkg::DCL_COORD_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // x_coord, y_coord
    input  logic [dcl_pkg::OP_W-1:0]          s_tuser,   // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // point_index, cluster_id
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcl_pkg::EPS_W-1:0]         cfg_data
);
    import dcl_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CB = COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_CNT, S_CNT_WAIT, S_VISIT,
        S_EXP_ISSUE, S_EXP_WAIT, S_POP, S_POP_WAIT, S_EMIT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     pc_reg, qi_reg, res_reg, e_reg;
    logic [AW-1:0]     k_reg;
    logic [LBL_W-1:0]  cl_reg;
    logic [EPS_W-1:0]  eps_reg;
    logic [CNT_W-1:0]  minp_reg;
    logic              cnt_vld_reg;
    logic [MAX_POINTS-1:0] core_reg;
    logic              m_valid_reg, m_last_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [LBL_W-1:0]  m_lbl_reg;

    cmd_t                 cmd;
    logic [AW-1:0]        cmd_idx, rd_addr;
    logic signed [CB-1:0] xin, yin;
    logic [2*CB-1:0]      rd_data;
    logic                 s_acc, take, q_pop, q_restart, q_empty, q_push;
    logic [AW-1:0]        q_rd_idx;
    logic                 cur_unc, cur_core;

    tok_t                 tok   [MAX_POINTS+1];
    logic signed [CB-1:0] qx    [MAX_POINTS+1];
    logic signed [CB-1:0] qy    [MAX_POINTS+1];
    logic [LBL_W-1:0]     lbl   [MAX_POINTS+1];
    logic [MAX_POINTS-1:0] unc_vec, push_vec;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign take      = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {3'b000, m_lbl_reg, m_idx_reg};

    assign xin = CB'(signed'(s_tdata[IN_COORD_W-1:0]));
    assign yin = CB'(signed'(s_tdata[2*IN_COORD_W-1:IN_COORD_W]));

    assign cur_unc  = unc_vec[qi_reg[AW-1:0]];
    assign cur_core = core_reg[qi_reg[AW-1:0]];
    assign q_push   = |push_vec;

    always_comb begin
        cmd       = '0;
        cmd_idx   = qi_reg[AW-1:0];
        rd_addr   = qi_reg[AW-1:0];
        q_pop     = 1'b0;
        q_restart = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && s_tuser == OP_LOAD && pc_reg < CW'(MAX_POINTS)) begin
                    cmd.load = 1'b1;
                    cmd_idx  = pc_reg[AW-1:0];
                end
                if (s_acc && s_tuser == OP_CLEAR) begin
                    cmd.clr_pts = 1'b1;
                end
            end
            S_CLEAR: cmd.clr_lbl = 1'b1;
            S_VISIT: begin
                if (qi_reg != pc_reg && cur_unc) begin
                    cmd.set_lbl = 1'b1;
                    cmd.lbl     = cur_core ? cl_reg : LBL_NOISE;
                    q_restart   = cur_core;
                end
            end
            S_POP:      q_pop   = !q_empty;
            S_POP_WAIT: rd_addr = q_rd_idx;
            S_EMIT:     cmd.shift = take && (e_reg != pc_reg);
            default: ;
        endcase
    end

    always_comb begin
        tok[0].valid  = cnt_vld_reg || (state_reg == S_EXP_ISSUE);
        tok[0].expand = (state_reg == S_EXP_ISSUE);
        tok[0].cnt    = '0;
        tok[0].id     = cl_reg;
    end
    assign qx[0] = rd_data[CB-1:0];
    assign qy[0] = rd_data[2*CB-1:CB];
    assign lbl[MAX_POINTS] = LBL_NOISE;

    dcl_point_mem #(.W(2*CB), .DEPTH(MAX_POINTS), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (cmd.load),
        .wr_addr (cmd_idx),
        .wr_data ({yin, xin}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dcl_seed_queue #(.DEPTH(MAX_POINTS), .AW(AW), .CW(CW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (q_restart),
        .push     (q_push),
        .push_idx (k_reg),
        .pop      (q_pop),
        .rd_idx   (q_rd_idx),
        .empty    (q_empty)
    );

    for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
        dcl_cell #(.COORD_BITS(CB), .AW(AW), .CELL_IDX(j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .cmd_idx  (cmd_idx),
            .cmd_x    (xin),
            .cmd_y    (yin),
            .eps      (eps_reg),
            .tok_in   (tok[j]),
            .qx_in    (qx[j]),
            .qy_in    (qy[j]),
            .tok_out  (tok[j+1]),
            .qx_out   (qx[j+1]),
            .qy_out   (qy[j+1]),
            .lbl_in   (lbl[j+1]),
            .lbl_out  (lbl[j]),
            .unc_out  (unc_vec[j]),
            .push_out (push_vec[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            qi_reg      <= '0;
            res_reg     <= '0;
            e_reg       <= '0;
            k_reg       <= '0;
            cl_reg      <= LBL_W'(1);
            eps_reg     <= EPS_W'(1);
            minp_reg    <= CNT_W'(4);
            cnt_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_EPS:    eps_reg  <= cfg_data;
                    REG_MINPTS: minp_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            cnt_vld_reg <= (state_reg == S_CNT);
            // neighbour counts leave the row in query order
            if (tok[MAX_POINTS].valid && !tok[MAX_POINTS].expand) begin
                core_reg[res_reg[AW-1:0]] <= (tok[MAX_POINTS].cnt >= minp_reg);
                res_reg <= res_reg + CW'(1);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        case (s_tuser)
                            OP_LOAD: begin
                                if (pc_reg < CW'(MAX_POINTS)) begin
                                    pc_reg <= pc_reg + CW'(1);
                                end
                            end
                            OP_CLEAR: pc_reg <= '0;
                            OP_RUN: begin
                                if (pc_reg != '0) begin
                                    state_reg <= S_CLEAR;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLEAR: begin
                    qi_reg    <= '0;
                    res_reg   <= '0;
                    cl_reg    <= LBL_W'(1);
                    state_reg <= S_CNT;
                end
                S_CNT: begin
                    qi_reg <= qi_reg + CW'(1);
                    if (qi_reg == pc_reg - CW'(1)) begin
                        state_reg <= S_CNT_WAIT;
                    end
                end
                S_CNT_WAIT: begin
                    if (res_reg == pc_reg) begin
                        qi_reg    <= '0;
                        state_reg <= S_VISIT;
                    end
                end
                S_VISIT: begin
                    if (qi_reg == pc_reg) begin
                        e_reg     <= '0;
                        state_reg <= S_EMIT;
                    end else if (!cur_unc || !cur_core) begin
                        qi_reg <= qi_reg + CW'(1);
                    end else begin
                        state_reg <= S_EXP_ISSUE;
                    end
                end
                S_EXP_ISSUE: begin
                    k_reg     <= '0;
                    state_reg <= S_EXP_WAIT;
                end
                S_EXP_WAIT: begin
                    k_reg <= k_reg + AW'(1);
                    if (k_reg == AW'(MAX_POINTS - 1)) begin
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    if (q_empty) begin
                        cl_reg    <= cl_reg + LBL_W'(1);
                        qi_reg    <= qi_reg + CW'(1);
                        state_reg <= S_VISIT;
                    end else begin
                        state_reg <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT: begin
                    state_reg <= core_reg[q_rd_idx] ? S_EXP_ISSUE : S_POP;
                end
                S_EMIT: begin
                    if (take) begin
                        if (e_reg != pc_reg) begin
                            m_valid_reg <= 1'b1;
                            m_idx_reg   <= IDX_W'(e_reg);
                            m_lbl_reg   <= lbl[0];
                            m_last_reg  <= (e_reg == pc_reg - CW'(1));
                            e_reg       <= e_reg + CW'(1);
                        end else begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/dcl_port_checker.sv @@
// Port-level checks on the density cluster labeler, bound to the top level.
// Depends on dcl_pkg for op codes.
module dcl_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [31:0]                   s_tdata,
    input logic [dcl_pkg::OP_W-1:0]      s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [15:0]                   m_tdata,
    input logic                          m_tlast,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [dcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [dcl_pkg::EPS_W-1:0]     cfg_data
);
    import dcl_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // results only appear while the input side is closed
    a_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("result pending while input ready");

    // load and clear words do not stall the input
    a_short_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_LOAD || s_tuser == OP_CLEAR) |=> s_tready)
        else $error("load or clear word stalled the input");

    // nothing follows the last label of a run
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after last label");

endmodule

bind density_cluster_labeler dcl_port_checker u_port_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for density_cluster_labeler: point loads, clears and
// clustering runs, with each emitted label checked against a DBSCAN predictor.
// Depends on dcl_pkg and the density_cluster_labeler RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcl_pkg::*;

    localparam logic [OP_W-1:0]      OP_NONE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 8'd7;
    localparam logic [EPS_W-1:0]     EPS_TOP     = 33'h1_FFFC_0002;
    localparam int                   ITEM_TARGET = 140;
    localparam int                   IDLE_WAIT   = 16;
    localparam longint               CYCLE_LIMIT = 1_500_000;
    localparam int                   NO_LABEL    = 255;

    typedef struct packed {
        bit                   is_cfg;
        logic [OP_W-1:0]      op;
        logic [15:0]          x;
        logic [15:0]          y;
        logic [CFG_IDX_W-1:0] ridx;
        logic [EPS_W-1:0]     rval;
        bit                   typed;
        logic [6:0]           n_lbl;
        logic [LBL_W-1:0]     id_lbl;
    } dir_row_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [LBL_W-1:0] id;
        logic             last;
    } label_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = OP_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [EPS_W-1:0]     cfg_data = '0;

    // predictor copy of the block state
    logic signed [15:0] pt_x [DCL_MAX_POINTS];
    logic signed [15:0] pt_y [DCL_MAX_POINTS];
    int                 pt_count = 0;
    logic [EPS_W-1:0]   eps_sq = 33'd1;
    logic [6:0]         min_pts = 7'd4;
    int                 lbl [DCL_MAX_POINTS];

    label_word_t label_q [$];
    int          errors = 0;
    int          items_sent = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    longint      cycles = 0;

    dir_row_t dir_tab [0:21] = '{
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 1, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h8000, 16'h7FFF, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h7FFF, 16'h8000, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 1, 7'd2, LBL_NOISE},
        '{0, OP_NONE,  16'hFFFF, 16'hFFFF, '0, '0, 1, 7'd0, LBL_NOISE},
        '{0, OP_CLEAR, 16'h0000, 16'h0000, '0, '0, 1, 7'd0, LBL_NOISE},
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 1, 7'd0, LBL_NOISE},
        '{1, OP_LOAD,  16'h0000, 16'h0000, REG_MINPTS, 33'd0, 0, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h0005, 16'h0005, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 1, 7'd1, 7'd1},
        '{1, OP_LOAD,  16'h0000, 16'h0000, REG_EPS, 33'd0, 0, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h0005, 16'h0005, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h0006, 16'h0005, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 0, 7'd0, LBL_NOISE},
        '{1, OP_LOAD,  16'h0000, 16'h0000, REG_UNUSED, 33'h1_2345_6789, 0, 7'd0, LBL_NOISE},
        '{1, OP_LOAD,  16'h0000, 16'h0000, REG_EPS, EPS_TOP, 0, 7'd0, LBL_NOISE},
        '{1, OP_LOAD,  16'h0000, 16'h0000, REG_MINPTS, 33'd64, 0, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h8000, 16'h8000, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_LOAD,  16'h7FFF, 16'h7FFF, '0, '0, 0, 7'd0, LBL_NOISE},
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 0, 7'd0, LBL_NOISE},
        '{1, OP_LOAD,  16'h0000, 16'h0000, REG_MINPTS, 33'd2, 0, 7'd0, LBL_NOISE},
        '{0, OP_RUN,   16'h0000, 16'h0000, '0, '0, 0, 7'd0, LBL_NOISE}
    };

    density_cluster_labeler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit is_near(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(pt_x[a]) - longint'(pt_x[b]);
        dy = longint'(pt_y[a]) - longint'(pt_y[b]);
        return (dx * dx + dy * dy) <= longint'({31'd0, eps_sq});
    endfunction

    function automatic int near_count(int p);
        int n;
        n = 0;
        for (int j = 0; j < pt_count; j++)
            if (is_near(p, j))
                n++;
        return n;
    endfunction

    // absorb neighbors of p into cluster id; unlabeled ones join the seed list
    function automatic void absorb(int p, int id, ref int seeds [$]);
        for (int j = 0; j < pt_count; j++) begin
            if (j == p || !is_near(p, j))
                continue;
            if (lbl[j] == NO_LABEL) begin
                lbl[j] = id;
                seeds = {seeds, j};
            end else if (lbl[j] == 0) begin
                lbl[j] = id;
            end
        end
    endfunction

    function automatic void predict_labels();
        int          seeds [$];
        int          next_id;
        int          q;
        label_word_t w;
        next_id = 1;
        for (int i = 0; i < DCL_MAX_POINTS; i++)
            lbl[i] = NO_LABEL;
        for (int i = 0; i < pt_count; i++) begin
            if (lbl[i] != NO_LABEL)
                continue;
            if (near_count(i) < int'(min_pts)) begin
                lbl[i] = 0;
                continue;
            end
            lbl[i] = next_id;
            seeds.delete();
            absorb(i, next_id, seeds);
            while (seeds.size() > 0) begin
                q = seeds.pop_front();
                if (near_count(q) >= int'(min_pts))
                    absorb(q, next_id, seeds);
            end
            next_id = (next_id + 1) & 8'h7F;
        end
        for (int i = 0; i < pt_count; i++) begin
            w.idx  = i[IDX_W-1:0];
            w.id   = lbl[i][LBL_W-1:0];
            w.last = (i + 1 == pt_count);
            label_q = {label_q, w};
        end
    endfunction

    function automatic void apply_item(logic [OP_W-1:0] op, logic [15:0] x, logic [15:0] y);
        case (op)
            OP_LOAD: begin
                if (pt_count < DCL_MAX_POINTS) begin
                    pt_x[pt_count] = x;
                    pt_y[pt_count] = y;
                    pt_count++;
                end
            end
            OP_CLEAR: pt_count = 0;
            OP_RUN:   predict_labels();
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [15:0] x, logic [15:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
        apply_item(op, x, y);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (label_q.size() > 0)
            @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_EPS)
            eps_sq = val;
        else if (idx == REG_MINPTS)
            min_pts = val[6:0];
    endtask

    task automatic add_typed(dir_row_t row);
        label_word_t w;
        for (int i = 0; i < int'(row.n_lbl); i++) begin
            w.idx  = i[IDX_W-1:0];
            w.id   = row.id_lbl;
            w.last = (i + 1 == int'(row.n_lbl));
            label_q = {label_q, w};
        end
    endtask

    // expectations of typed rows replace the predicted ones
    task automatic run_directed();
        int keep;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                wait_idle();
                write_reg(dir_tab[k].ridx, dir_tab[k].rval);
            end else begin
                keep = label_q.size();
                send_item(dir_tab[k].op, dir_tab[k].x, dir_tab[k].y);
                if (dir_tab[k].typed) begin
                    while (label_q.size() > keep)
                        void'(label_q.pop_back());
                    add_typed(dir_tab[k]);
                end
            end
        end
    endtask

    task automatic run_random();
        int          phase;
        int          n_pts;
        int          spread;
        int          n_ctr;
        logic [15:0] cx [4];
        logic [15:0] cy [4];
        logic [15:0] px;
        logic [15:0] py;
        int          c;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: write_reg(REG_EPS, 33'd0);
                1: write_reg(REG_EPS, EPS_TOP);
                2: write_reg(REG_EPS, 33'($urandom_range(1, 50)));
                default: write_reg(REG_EPS, 33'($urandom_range(100, 5000)));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(REG_MINPTS, 33'd1);
                1: write_reg(REG_MINPTS, 33'd64);
                default: write_reg(REG_MINPTS, 33'($urandom_range(2, 5)));
            endcase
            send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
            n_pts = (phase == 2) ? 70 : $urandom_range(1, 12);
            if (phase == 2)
                hold_req = 1;
            spread = $urandom_range(0, 60);
            n_ctr = $urandom_range(1, 4);
            for (int i = 0; i < n_ctr; i++) begin
                cx[i] = 16'($urandom);
                cy[i] = 16'($urandom);
            end
            for (int i = 0; i < n_pts; i++) begin
                c = $urandom_range(0, n_ctr - 1);
                if ($urandom_range(0, 5) == 0) begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end else begin
                    px = cx[c] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                    py = cy[c] + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                end
                if ($urandom_range(0, 19) == 0)
                    send_item(($urandom_range(0, 1) == 0) ? OP_NONE : OP_RUN, px, py);
                send_item(OP_LOAD, px, py);
            end
            send_item(OP_RUN, 16'($urandom), 16'($urandom));
            // keep offering a word while the receiver holds off
            if (phase == 2 || $urandom_range(0, 3) == 0)
                send_item(OP_RUN, 16'($urandom), 16'($urandom));
            phase++;
        end
    endtask

    // receiver flow control, with one long hold-off once labels start flowing
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done && m_tvalid) begin
            hold_done  = 1;
            hold_left  = 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready  <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        label_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (label_q.size() == 0) begin
                $display("%0t: unexpected label word idx=%0d id=%0d last=%0b", $realtime,
                         m_tdata[5:0], m_tdata[12:6], m_tlast);
                errors++;
            end else begin
                w = label_q.pop_front();
                if (m_tdata[5:0] !== w.idx || m_tdata[12:6] !== w.id || m_tlast !== w.last) begin
                    $display("%0t: label mismatch exp idx=%0d id=%0d last=%0b, got idx=%0d id=%0d last=%0b",
                             $realtime, w.idx, w.id, w.last, m_tdata[5:0], m_tdata[12:6], m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        wait_idle();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ density_cluster_labeler.f @@
design/dcl_pkg.sv
design/dcl_cell.sv
design/dcl_point_mem.sv
design/dcl_seed_queue.sv
design/density_cluster_labeler.sv
design/dcl_port_checker.sv
tb/tb_top.sv
